>>> hw/rtl/ccsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Custom collation sort check package
// Shared types, request codes and helpers for the order checker.
// ----------------------------------------------------------------------------
package ccsc_pkg;

    localparam int CHAR_W           = 8;
    localparam int CHAR_NUM         = 256;
    localparam int RANK_W           = 6;
    localparam int COUNT_W          = 16;
    localparam int MAX_WORD_LEN_DEF = 64;
    localparam int ALPHABET_MAX_DEF = 32;

    localparam logic [RANK_W-1:0]  NOT_IN_ALPHABET = 6'd63;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

    typedef enum logic [2:0] {
        REQ_START  = 3'd0,
        REQ_LETTER = 3'd1,
        REQ_CHAR   = 3'd2,
        REQ_EOW    = 3'd3,
        REQ_EOL    = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        DEC_UNDECIDED    = 2'd0,
        DEC_IN_ORDER     = 2'd1,
        DEC_OUT_OF_ORDER = 2'd2
    } t_dec;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [CHAR_W-1:0] char_code;
    } t_in_word;

    typedef struct packed {
        logic               list_sorted;
        logic [COUNT_W-1:0] words_seen;
    } t_out_word;

    // Control that travels with an item from the lookup stage to the judge stage.
    typedef struct packed {
        logic               valid;
        logic [2:0]         req;
        logic               take_char;
        logic               shorter;
        logic               have_prev;
        logic               rank_vld;
        logic [COUNT_W-1:0] count;
    } t_s1_ctl;

    // Only upper-case ASCII letters fold; every other byte stays distinct.
    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] f;
        f = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            f = c + 8'h20;
        end
        return f;
    endfunction

endpackage

>>> hw/rtl/ccsc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ccsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/ccsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lookup stage
// Keeps the counters and rank valid bits, issues table and store reads.
// ----------------------------------------------------------------------------
module ccsc_front import ccsc_pkg::*; #(
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
    parameter int ALPHABET_MAX = ALPHABET_MAX_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  t_in_word                              i_in_word,
    input  logic                                  i_s1_hold,
    output logic                                  o_rank_we,
    output logic [CHAR_W-1:0]                     o_rank_waddr,
    output logic [RANK_W-1:0]                     o_rank_wdata,
    output logic [CHAR_W-1:0]                     o_rank_raddr,
    output logic [$clog2(2*MAX_WORD_LEN)-1:0]     o_ws_raddr,
    output logic [$clog2(2*MAX_WORD_LEN)-1:0]     o_ws_waddr,
    output t_s1_ctl                               o_s1
);

    localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
    localparam int AL_W  = $clog2(ALPHABET_MAX + 1);
    localparam int WS_AW = $clog2(2 * MAX_WORD_LEN);
    localparam logic [WS_AW-1:0] HALF    = WS_AW'(MAX_WORD_LEN);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD_LEN);
    localparam logic [AL_W-1:0]  AL_MAX  = AL_W'(ALPHABET_MAX);

    logic [LEN_W-1:0]    r_cur_len;
    logic [LEN_W-1:0]    r_prev_len;
    logic [AL_W-1:0]     r_alpha_len;
    logic                r_have_prev;
    logic                r_buf_sel;
    logic [COUNT_W-1:0]  r_count;
    logic [CHAR_NUM-1:0] r_rank_vld;
    t_s1_ctl             r_s1;
    logic [WS_AW-1:0]    r_ws_waddr;

    t_s1_ctl             n_s1;
    logic [WS_AW-1:0]    n_ws_waddr;
    logic [CHAR_W-1:0]   ch;
    logic [2:0]          req;
    logic                take_char;
    logic                shorter;
    logic                letter_ok;

    always_comb begin
        ch        = fold_case(i_in_word.char_code);
        req       = i_in_word.req_type;
        take_char = r_cur_len < LEN_MAX;
        shorter   = r_have_prev && (r_cur_len < r_prev_len);
        letter_ok = r_alpha_len < AL_MAX;

        n_ws_waddr = (r_buf_sel ? HALF : '0) + WS_AW'(r_cur_len);

        n_s1.valid     = i_accept;
        n_s1.req       = req;
        n_s1.take_char = take_char;
        n_s1.shorter   = shorter;
        n_s1.have_prev = r_have_prev;
        n_s1.rank_vld  = r_rank_vld[ch];
        n_s1.count     = r_count;
    end

    assign o_rank_we    = i_accept && (req == REQ_LETTER) && letter_ok;
    assign o_rank_waddr = ch;
    assign o_rank_wdata = RANK_W'(r_alpha_len);
    assign o_rank_raddr = ch;
    assign o_ws_raddr   = (r_buf_sel ? '0 : HALF) + WS_AW'(r_cur_len);
    assign o_ws_waddr   = r_ws_waddr;
    assign o_s1         = r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_len   <= '0;
            r_prev_len  <= '0;
            r_alpha_len <= '0;
            r_have_prev <= 1'b0;
            r_buf_sel   <= 1'b0;
            r_count     <= '0;
            r_rank_vld  <= '0;
            r_s1        <= '0;
        end else begin
            if (i_accept) begin
                case (req)
                    REQ_START: begin
                        r_cur_len   <= '0;
                        r_prev_len  <= '0;
                        r_alpha_len <= '0;
                        r_have_prev <= 1'b0;
                        r_buf_sel   <= 1'b0;
                        r_count     <= '0;
                        r_rank_vld  <= '0;
                    end
                    REQ_LETTER: begin
                        if (letter_ok) begin
                            r_rank_vld[ch] <= 1'b1;
                            r_alpha_len    <= r_alpha_len + 1'b1;
                        end
                    end
                    REQ_CHAR: begin
                        if (take_char) begin
                            r_cur_len <= r_cur_len + 1'b1;
                        end
                    end
                    REQ_EOW: begin
                        r_prev_len  <= r_cur_len;
                        r_cur_len   <= '0;
                        r_buf_sel   <= !r_buf_sel;
                        r_have_prev <= 1'b1;
                        if (r_count != COUNT_MAX) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (!i_s1_hold) begin
                r_s1 <= n_s1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_s1_hold) begin
            r_ws_waddr <= n_ws_waddr;
        end
    end

    a_eow_clears_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_in_word.req_type == REQ_EOW) |=> (r_cur_len == '0) && r_have_prev)
        else $error("word end did not restart the length");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_len <= LEN_MAX)
        else $error("word length ran past the limit");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_in_word.req_type == REQ_START)
            |=> (r_rank_vld == '0) && (r_alpha_len == '0) && (r_count == '0))
        else $error("start of run left alphabet or count behind");

endmodule

>>> hw/rtl/ccsc_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Judge stage
// Compares ranks, writes the current word back, keeps the verdict.
// ----------------------------------------------------------------------------
module ccsc_judge import ccsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_s1_ctl           i_s1,
    input  logic [RANK_W-1:0] i_rank_rdata,
    input  logic [RANK_W-1:0] i_ws_rdata,
    input  logic              i_out_stall,
    output logic              o_ws_we,
    output logic [RANK_W-1:0] o_ws_wdata,
    output logic              o_s1_hold,
    output logic              o_out_valid,
    output t_out_word         o_out_word
);

    t_dec        r_dec;
    logic        r_all;
    logic        r_out_valid;
    t_out_word   r_out;

    t_dec        n_dec;
    logic        n_all;
    logic [RANK_W-1:0] rank;
    logic        is_eol;
    logic        eol_go;

    always_comb begin
        rank   = i_s1.rank_vld ? i_rank_rdata : NOT_IN_ALPHABET;
        is_eol = i_s1.valid && (i_s1.req == REQ_EOL);
        eol_go = is_eol && !(r_out_valid && i_out_stall);
        n_dec  = r_dec;
        n_all  = r_all;
        if (i_s1.valid) begin
            case (i_s1.req)
                REQ_START: begin
                    n_dec = DEC_UNDECIDED;
                    n_all = 1'b1;
                end
                REQ_CHAR: begin
                    if (i_s1.take_char && i_s1.shorter && (r_dec == DEC_UNDECIDED)) begin
                        if (i_ws_rdata < rank) begin
                            n_dec = DEC_IN_ORDER;
                        end else if (i_ws_rdata > rank) begin
                            n_dec = DEC_OUT_OF_ORDER;
                        end
                    end
                end
                REQ_EOW: begin
                    // A shorter word still tied with its predecessor sorts too late.
                    if (i_s1.have_prev) begin
                        if (r_dec == DEC_OUT_OF_ORDER ||
                            (r_dec == DEC_UNDECIDED && i_s1.shorter)) begin
                            n_all = 1'b0;
                        end
                    end
                    n_dec = DEC_UNDECIDED;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_ws_we     = i_s1.valid && (i_s1.req == REQ_CHAR) && i_s1.take_char;
    assign o_ws_wdata  = rank;
    assign o_s1_hold   = is_eol && !eol_go;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec       <= DEC_UNDECIDED;
            r_all       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_dec <= n_dec;
            r_all <= n_all;
            if (eol_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (eol_go) begin
            r_out.list_sorted <= r_all;
            r_out.words_seen  <= i_s1.count;
        end
    end

    a_eol_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eol_go |=> r_out_valid && (r_out.words_seen == $past(i_s1.count)))
        else $error("end of list did not load the result register");

    a_dec_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dec != DEC_UNDECIDED) &&
            !(i_s1.valid && (i_s1.req == REQ_EOW || i_s1.req == REQ_START))
            |=> r_dec == $past(r_dec))
        else $error("a decided pair changed its decision");

    a_verdict_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_all && !(i_s1.valid && (i_s1.req == REQ_START)) |=> !r_all)
        else $error("out-of-order verdict was lost");

endmodule

>>> hw/rtl/custom_collation_sort_check_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Custom collation sort check
// Checks that a stream of words is in non-decreasing order under a loaded,
// case-blind alphabet and reports the verdict and word count at list end.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                               Direction   Carries
//   -------   -----------------------------------   ---------   -------------------
//   input     i_in_valid, o_in_stall, i_in_word     in          request and byte
//   output    o_out_valid, i_out_stall, o_out_word  out         verdict and count
//
// One request is taken every cycle while the input is not stalled. Each request
// passes two stages: the lookup stage issues the rank table read and the
// previous-word store read, and the judge stage compares the two ranks and
// writes the new rank back into the store. An end-of-list result is registered
// in the lookup stage and then loaded into the output register. Reset is
// synchronous and active low; the rank table needs no clearing pass because
// each of its 256 entries has a valid bit that reset clears. The input is
// stalled during reset and otherwise only while an end-of-list word waits in
// the judge stage behind a full, stalled output register.
module custom_collation_sort_check_top import ccsc_pkg::*; #(
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
    parameter int ALPHABET_MAX = ALPHABET_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int WS_AW = $clog2(2 * MAX_WORD_LEN);

    // The hold freezes the input and the lookup stage register, so a waiting result
    // freezes the front of the pipe without losing anything in flight.
    logic              s1_hold;
    logic              accept;
    t_s1_ctl           s1;

    // Rank table: indexed by the folded byte, written by alphabet letters.
    logic              rank_we;
    logic [CHAR_W-1:0] rank_waddr;
    logic [RANK_W-1:0] rank_wdata;
    logic [CHAR_W-1:0] rank_raddr;
    logic [RANK_W-1:0] rank_rdata;

    // Word store: two halves, the current word and the previous word, which
    // swap roles at every word end.
    logic              ws_we;
    logic [WS_AW-1:0]  ws_waddr;
    logic [RANK_W-1:0] ws_wdata;
    logic [WS_AW-1:0]  ws_raddr;
    logic [RANK_W-1:0] ws_rdata;

    // Nothing is taken while reset is held.
    assign o_in_stall = s1_hold || !i_rst_n;
    assign accept     = i_in_valid && !o_in_stall;

    ccsc_front #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .ALPHABET_MAX (ALPHABET_MAX)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_in_word    (i_in_word),
        .i_s1_hold    (s1_hold),
        .o_rank_we    (rank_we),
        .o_rank_waddr (rank_waddr),
        .o_rank_wdata (rank_wdata),
        .o_rank_raddr (rank_raddr),
        .o_ws_raddr   (ws_raddr),
        .o_ws_waddr   (ws_waddr),
        .o_s1         (s1)
    );

    ccsc_ram #(
        .WIDTH (RANK_W),
        .DEPTH (CHAR_NUM)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rank_we),
        .i_waddr (rank_waddr),
        .i_wdata (rank_wdata),
        .i_raddr (rank_raddr),
        .o_rdata (rank_rdata)
    );

    // A store write in the judge stage always lands before any later read
    // of the same half, so the store needs no forwarding path.
    ccsc_ram #(
        .WIDTH (RANK_W),
        .DEPTH (2 * MAX_WORD_LEN)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (ws_we),
        .i_waddr (ws_waddr),
        .i_wdata (ws_wdata),
        .i_raddr (ws_raddr),
        .o_rdata (ws_rdata)
    );

    ccsc_judge u_judge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1         (s1),
        .i_rank_rdata (rank_rdata),
        .i_ws_rdata   (ws_rdata),
        .i_out_stall  (i_out_stall),
        .o_ws_we      (ws_we),
        .o_ws_wdata   (ws_wdata),
        .o_s1_hold    (s1_hold),
        .o_out_valid  (o_out_valid),
        .o_out_word   (o_out_word)
    );

endmodule
